// ===== hw/rtl/coalescing_notification_queue_macros.svh =====
// Assertion macros shared by the RTL. Clock is aclk, reset is aresetn (active low).
`ifndef COALESCING_NOTIFICATION_QUEUE_MACROS_SVH
`define COALESCING_NOTIFICATION_QUEUE_MACROS_SVH

`ifndef SYNTHESIS
// prop must hold at every edge out of reset
`define CNQ_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error("cnq assertion failed");
// cond must never be true out of reset
`define CNQ_NEVER(lbl, cond) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) \
        else $error("cnq forbidden condition seen");
`else
`define CNQ_ASSERT(lbl, prop)
`define CNQ_NEVER(lbl, cond)
`endif

`endif

// ===== hw/rtl/cnq_pkg.sv =====
`timescale 1ns / 1ps

package cnq_pkg;

    localparam int ID_W     = 16;
    localparam int PATH_W   = 3 * ID_W;
    localparam int STATUS_W = 3;

    // tuser on the slave side
    localparam logic ACT_ADD   = 1'b0;
    localparam logic ACT_DRAIN = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_ADDED     = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_FULL      = 3'd2,
        ST_EMITTED   = 3'd3,
        ST_EMPTY     = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN
    } state_t;

endpackage

// ===== hw/rtl/coalescing_notification_queue.sv =====
`timescale 1ns / 1ps
// Coalescing notification queue: a small deduplicating FIFO of resource paths.
// Slave channel (s_*): one beat per request. s_tuser = 0 adds the path in
// s_tdata, s_tuser = 1 drains the queue. Master channel (m_*): result beats,
// m_tuser holds the status, m_tlast marks the final beat of a request.
// An add returns one beat (added, duplicate or full). A drain returns one
// beat per stored path, oldest first, then leaves the queue empty; a drain on
// an empty queue returns a single "empty" beat.
// Paths live in a single-port-write, registered-read memory. An add walks the
// N stored entries through that read port, one per cycle, and compares each
// with the new path. A drain reads one entry per cycle while the receiver
// does not stall and sends each one out. One request is handled at a time;
// s_tready is high only between requests and stays low during reset.
// The result register decouples the sides: a finished result waits there
// while the next request is taken. When m_tready is low, a drain stops
// reading and an add holds its result until the register frees up, and
// nothing is lost or repeated.
// Reset (aresetn low, synchronous) empties the queue and drops any beat in
// flight; memory contents are not cleared, only the entry count.
`include "coalescing_notification_queue_macros.svh"

module coalescing_notification_queue #(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // [15:0] obj_id, [31:16] inst_id, [47:32] res_id
    input  logic [cnq_pkg::PATH_W-1:0]   s_tdata,
    // [0] action
    input  logic                         s_tuser,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // [15:0] out_object, [31:16] out_instance, [47:32] out_resource
    output logic [cnq_pkg::PATH_W-1:0]   m_tdata,
    // [2:0] status
    output logic [cnq_pkg::STATUS_W-1:0] m_tuser,
    output logic                         m_tlast
);

    import cnq_pkg::*;

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    // path memory, registered read
    logic [PATH_W-1:0] mem [QUEUE_DEPTH];
    logic [PATH_W-1:0] rd_data_reg;
    logic              rd_en;
    logic              wr_en;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;       // stored entries
    logic [CNT_W-1:0]  rd_idx_reg, rd_idx_next; // next entry to read
    logic              pend_reg, pend_next;     // rd_data_reg holds an unused read
    logic              pend_last_reg, pend_last_next;
    logic              match_reg, match_next;
    logic              match_now;
    logic              move;
    logic              issue;
    logic              out_free;

    logic [PATH_W-1:0] key_reg;
    logic              act_reg;
    logic              s_accept;

    logic              out_vld_reg, out_vld_next;
    logic              out_load;
    status_t           out_status_next;
    logic [PATH_W-1:0] out_path_next;
    logic              out_last_next;
    status_t           out_status_reg;
    logic [PATH_W-1:0] out_path_reg;
    logic              out_last_reg;

    assign s_accept = s_tvalid && s_tready;
    assign out_free = !out_vld_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[cnt_reg[IDX_W-1:0]] <= key_reg;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_idx_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            key_reg <= s_tdata;
            act_reg <= s_tuser;
        end
        if (out_load) begin
            out_status_reg <= out_status_next;
            out_path_reg   <= out_path_next;
            out_last_reg   <= out_last_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            rd_idx_reg    <= '0;
            pend_reg      <= 1'b0;
            pend_last_reg <= 1'b0;
            match_reg     <= 1'b0;
            out_vld_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rd_idx_reg    <= rd_idx_next;
            pend_reg      <= pend_next;
            pend_last_reg <= pend_last_next;
            match_reg     <= match_next;
            out_vld_reg   <= out_vld_next;
        end
    end

    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        rd_idx_next     = rd_idx_reg;
        pend_next       = 1'b0;
        pend_last_next  = 1'b0;
        match_next      = match_reg;
        out_vld_next    = out_vld_reg && !m_tready;
        out_load        = 1'b0;
        out_status_next = ST_ADDED;
        out_path_next   = '0;
        out_last_next   = 1'b1;
        rd_en           = 1'b0;
        wr_en           = 1'b0;
        s_tready        = 1'b0;
        issue           = 1'b0;
        move            = 1'b0;
        match_now       = match_reg || (pend_reg && (rd_data_reg == key_reg));

        case (state_reg)
            S_IDLE: begin
                s_tready = aresetn;
                if (s_tvalid) begin
                    rd_idx_next = '0;
                    match_next  = 1'b0;
                    // a drain of an empty queue goes through the scan path
                    if (s_tuser == ACT_DRAIN && cnt_reg != '0) begin
                        state_next = S_DRAIN;
                    end else begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN: begin
                issue      = (rd_idx_reg != cnt_reg);
                rd_en      = issue;
                pend_next  = issue;
                match_next = match_now;
                if (issue) begin
                    rd_idx_next = rd_idx_reg + CNT_W'(1);
                end else if (out_free) begin
                    out_load     = 1'b1;
                    out_vld_next = 1'b1;
                    state_next   = S_IDLE;
                    if (act_reg == ACT_DRAIN) begin
                        out_status_next = ST_EMPTY;
                    end else if (match_now) begin
                        out_status_next = ST_DUPLICATE;
                    end else if (cnt_reg == CNT_FULL) begin
                        out_status_next = ST_FULL;
                    end else begin
                        out_status_next = ST_ADDED;
                        wr_en           = 1'b1;
                        cnt_next        = cnt_reg + CNT_W'(1);
                    end
                end
            end

            S_DRAIN: begin
                move  = pend_reg && out_free;
                issue = (rd_idx_reg != cnt_reg) && (!pend_reg || move);
                rd_en = issue;
                pend_next = issue || (pend_reg && !move);
                if (issue) begin
                    rd_idx_next    = rd_idx_reg + CNT_W'(1);
                    pend_last_next = ((rd_idx_reg + CNT_W'(1)) == cnt_reg);
                end else begin
                    pend_last_next = pend_reg && !move && pend_last_reg;
                end
                if (move) begin
                    out_load        = 1'b1;
                    out_vld_next    = 1'b1;
                    out_status_next = ST_EMITTED;
                    out_path_next   = rd_data_reg;
                    out_last_next   = pend_last_reg;
                    if (pend_last_reg) begin
                        cnt_next   = '0;
                        state_next = S_IDLE;
                    end
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_path_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

    // queue never holds more than its depth
    `CNQ_ASSERT(a_cnt_bound, cnt_reg <= CNT_FULL)
    // reads stay inside the stored entries
    `CNQ_NEVER(a_rd_in_range, rd_en && (rd_idx_reg >= cnt_reg))
    // a drain always ends with the queue empty
    `CNQ_ASSERT(a_drain_empties, (state_reg == S_DRAIN && state_next == S_IDLE) |=> cnt_reg == '0)
    // no memory write while a drain is reading entries out
    `CNQ_NEVER(a_no_wr_in_drain, wr_en && (state_reg != S_SCAN))

endmodule

// ===== bench/tb_coalescing_notification_queue.sv =====
`timescale 1ns / 1ps

module tb_coalescing_notification_queue;
    import cnq_pkg::*;

    localparam int DEPTH        = 8;
    localparam int TOTAL_ITEMS  = 310;
    localparam int CALM_ITEMS   = 40;      // final stretch with no idling on either side
    localparam int SETTLE       = 2 * DEPTH + 24;
    localparam int CYCLE_LIMIT  = 400000;

    // path layout matches tdata: object in the low bits, resource on top
    typedef struct packed {
        logic [ID_W-1:0] res;
        logic [ID_W-1:0] inst;
        logic [ID_W-1:0] obj;
    } path_t;

    typedef struct packed {
        status_t status;
        path_t   path;
        logic    last;
    } beat_t;

    // Mirror of the queue: computes the result beats owed for each request and
    // checks the beats that come back against them, oldest first.
    class notification_scoreboard;
        path_t stored[DEPTH];
        int    fill;
        beat_t owed_beats[$];
        int    errors;
        int    requests;
        int    drains;
        int    beats_seen;
        int    per_status[5];

        function new();
            fill       = 0;
            errors     = 0;
            requests   = 0;
            drains     = 0;
            beats_seen = 0;
            foreach (per_status[i]) per_status[i] = 0;
        endfunction

        function void owe(status_t st, path_t p, logic lst);
            beat_t b;
            b.status = st;
            b.path   = p;
            b.last   = lst;
            owed_beats.push_back(b);
        endfunction

        function void note_request(logic action, path_t p);
            bit hit;
            hit = 0;
            requests++;
            if (action == ACT_ADD) begin
                // duplicate check comes first, so a stored path is a duplicate even when full
                for (int i = 0; i < fill; i++)
                    if (stored[i] == p) hit = 1;
                if (hit) begin
                    owe(ST_DUPLICATE, '0, 1'b1);
                end else if (fill >= DEPTH) begin
                    owe(ST_FULL, '0, 1'b1);
                end else begin
                    stored[fill] = p;
                    fill++;
                    owe(ST_ADDED, '0, 1'b1);
                end
            end else begin
                drains++;
                if (fill == 0) begin
                    owe(ST_EMPTY, '0, 1'b1);
                end else begin
                    for (int i = 0; i < fill; i++)
                        owe(ST_EMITTED, stored[i], (i == fill - 1));
                    fill = 0;
                end
            end
        endfunction

        function void check_beat(logic [STATUS_W-1:0] st, path_t p, logic lst);
            beat_t e;
            beats_seen++;
            if (owed_beats.size() == 0) begin
                $display("%0t: unexpected beat: status %0d path %h last %b",
                         $time, st, p, lst);
                errors++;
                return;
            end
            e = owed_beats.pop_front();
            if (st < 5) per_status[st]++;
            if (st !== e.status) begin
                $display("%0t: status mismatch: expected %0d actual %0d",
                         $time, e.status, st);
                errors++;
            end
            if (p.obj !== e.path.obj) begin
                $display("%0t: object mismatch: expected %h actual %h",
                         $time, e.path.obj, p.obj);
                errors++;
            end
            if (p.inst !== e.path.inst) begin
                $display("%0t: instance mismatch: expected %h actual %h",
                         $time, e.path.inst, p.inst);
                errors++;
            end
            if (p.res !== e.path.res) begin
                $display("%0t: resource mismatch: expected %h actual %h",
                         $time, e.path.res, p.res);
                errors++;
            end
            if (lst !== e.last) begin
                $display("%0t: last mismatch: expected %b actual %b",
                         $time, e.last, lst);
                errors++;
            end
        endfunction
    endclass

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [PATH_W-1:0]   s_tdata;   // [15:0] obj_id, [31:16] inst_id, [47:32] res_id
    logic                s_tuser;   // [0] action
    logic                m_tvalid;
    logic                m_tready;
    logic [PATH_W-1:0]   m_tdata;   // [15:0] out_object, [31:16] out_instance, [47:32] out_resource
    logic [STATUS_W-1:0] m_tuser;   // [2:0] status
    logic                m_tlast;

    notification_scoreboard sb;
    int    items_sent;
    bit    calm;
    int    cycle_count;
    path_t recent[$];   // paths added since the last drain, reused to provoke duplicates

    coalescing_notification_queue #(.QUEUE_DEPTH(DEPTH)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_beat(m_tuser, path_t'(m_tdata), m_tlast);
    end

    // receiver: ready and stall bursts, always ready in the final stretch
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (calm) begin
                m_tready <= 1'b1;
            end else if ($urandom_range(0, 2) != 0) begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 20) - 1) @(negedge aclk);
            end else begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17) - 1) @(negedge aclk);
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_request(logic action, path_t p);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= action;
        s_tdata  <= p;
        do @(posedge aclk); while (!s_tready);
        sb.note_request(action, p);
        items_sent++;
        if (items_sent >= TOTAL_ITEMS - CALM_ITEMS) calm = 1;
        @(negedge aclk);
    endtask

    task automatic add_path(logic [15:0] o, logic [15:0] i, logic [15:0] r);
        path_t p;
        p.obj  = o;
        p.inst = i;
        p.res  = r;
        send_request(ACT_ADD, p);
    endtask

    task automatic drain_queue();
        // path bits are don't-care on a drain
        send_request(ACT_DRAIN, path_t'(PATH_W'({$urandom, $urandom})));
        recent.delete();
    endtask

    // biased id: extremes and tiny values collide often, the rest is uniform
    function automatic logic [15:0] pick_id();
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(0, 3));
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        int    n_adds;
        path_t p;

        sb          = new();
        items_sent  = 0;
        calm        = 0;
        cycle_count = 0;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tuser     = ACT_ADD;
        s_tdata     = '0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: drain on empty, fill to the brim with extreme paths,
        // duplicate while full, drop while full, full drain, reuse after drain
        drain_queue();
        add_path(16'h0000, 16'h0000, 16'h0000);
        add_path(16'hFFFF, 16'hFFFF, 16'hFFFF);
        add_path(16'hFFFF, 16'h0000, 16'h0000);
        add_path(16'h0000, 16'hFFFF, 16'h0000);
        add_path(16'h0000, 16'h0000, 16'hFFFF);
        add_path(16'h0001, 16'h0002, 16'h0003);
        add_path(16'h8000, 16'h8000, 16'h8000);
        add_path(16'h5555, 16'hAAAA, 16'h5555);
        add_path(16'hFFFF, 16'hFFFF, 16'hFFFF);  // duplicate while full
        add_path(16'h1234, 16'h5678, 16'h9ABC);  // new path while full: dropped
        drain_queue();
        drain_queue();
        add_path(16'h0000, 16'h0000, 16'h0000);  // must be added again after drain
        add_path(16'h0000, 16'h0000, 16'h0000);
        add_path(16'h0000, 16'h0000, 16'h0001);  // one bit away from a stored path
        drain_queue();

        // random: bursts of adds with planted duplicates, mostly closed by a drain;
        // some bursts overflow, some run on without a drain, stray drains on top
        while (items_sent < TOTAL_ITEMS) begin
            n_adds = $urandom_range(0, 4) == 0 ? $urandom_range(9, 12)
                                               : $urandom_range(0, 8);
            for (int k = 0; k < n_adds && items_sent < TOTAL_ITEMS; k++) begin
                if (recent.size() != 0 && $urandom_range(0, 3) == 0) begin
                    p = recent[$urandom_range(0, recent.size() - 1)];
                end else begin
                    p.obj  = pick_id();
                    p.inst = pick_id();
                    p.res  = pick_id();
                    recent.push_back(p);
                end
                send_request(ACT_ADD, p);
            end
            if (items_sent < TOTAL_ITEMS && $urandom_range(0, 9) != 0)
                drain_queue();
            if (items_sent < TOTAL_ITEMS && $urandom_range(0, 9) == 0)
                drain_queue();
        end
        s_tvalid <= 1'b0;

        while (sb.owed_beats.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);

        $display("Ran %0d requests (%0d drains), checked %0d result beats",
                 sb.requests, sb.drains, sb.beats_seen);
        $display("added %0d, duplicate %0d, dropped %0d, emitted %0d, empty %0d",
                 sb.per_status[ST_ADDED], sb.per_status[ST_DUPLICATE],
                 sb.per_status[ST_FULL], sb.per_status[ST_EMITTED],
                 sb.per_status[ST_EMPTY]);
        if (sb.errors == 0 && sb.owed_beats.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
